### src/mrd_pkg.sv
package mrd_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [2:0] hdr_count_t;
    typedef logic [3:0] frame_off_t;

    // Header progress reaches this value once all sync bytes have matched.
    localparam hdr_count_t HDR_LEN     = 3'd5;
    localparam frame_off_t OFF_HDR_END = 4'd5;
    localparam frame_off_t OFF_BUTTONS = 4'd7;
    localparam frame_off_t OFF_X       = 4'd8;
    localparam frame_off_t OFF_Y       = 4'd10;
    localparam frame_off_t OFF_WHEEL   = 4'd12;
    localparam frame_off_t OFF_LAST    = 4'd13;

    localparam byte_t SYNC_0 = 8'h57;
    localparam byte_t SYNC_1 = 8'hAB;
    localparam byte_t SYNC_2 = 8'h88;
    localparam byte_t SYNC_3 = 8'h0A;
    localparam byte_t SYNC_4 = 8'h21;

    function automatic byte_t sync_byte(input hdr_count_t idx);
        byte_t b;
        case (idx)
            3'd0:    b = SYNC_0;
            3'd1:    b = SYNC_1;
            3'd2:    b = SYNC_2;
            3'd3:    b = SYNC_3;
            3'd4:    b = SYNC_4;
            default: b = SYNC_0;
        endcase
        return b;
    endfunction

endpackage

### src/mouse_report_deframer.sv
// Channel   Valid          Ready          Word
// rx        rx_valid       rx_ready       rx_byte
// report    report_valid   report_ready   button_bits, x/y/wheel delta, x/y/wheel total
//
// One byte is taken per cycle while no completing byte is stalled. A byte sits in the
// input register and is matched or captured from there; a report is registered into the
// output register when the last byte of its frame leaves the input register. Reset clears
// the header hunt, the frame offset, the captured fields and the running totals. While a
// report waits, bytes that complete no frame keep flowing; only a completing byte stalls.
module mouse_report_deframer
    import mrd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rx_valid,
    output logic              rx_ready,
    input  logic [7:0]        rx_byte,
    output logic              report_valid,
    input  logic              report_ready,
    output logic [7:0]        button_bits,
    output logic signed [7:0] x_delta,
    output logic signed [7:0] y_delta,
    output logic signed [7:0] wheel_delta,
    output logic signed [7:0] x_total,
    output logic signed [7:0] y_total,
    output logic signed [7:0] wheel_total
);

    logic       s1_valid_reg;
    byte_t      s1_byte_reg;
    hdr_count_t hdr_reg;
    frame_off_t off_reg;
    byte_t      held_buttons_reg;
    byte_t      held_x_reg;
    byte_t      held_y_reg;
    byte_t      held_wheel_reg;
    byte_t      sum_x_reg;
    byte_t      sum_y_reg;
    byte_t      sum_wheel_reg;
    logic       out_valid_reg;
    byte_t      out_buttons_reg;
    byte_t      out_x_reg;
    byte_t      out_y_reg;
    byte_t      out_wheel_reg;

    logic  hunting;
    logic  done_byte;
    logic  out_free;
    logic  s1_go;
    logic  rx_fire;
    byte_t sum_x_next;
    byte_t sum_y_next;
    byte_t sum_wheel_next;

    assign hunting   = (hdr_reg != HDR_LEN);
    assign done_byte = !hunting && (off_reg >= OFF_LAST);
    assign out_free  = !out_valid_reg || report_ready;
    assign s1_go     = s1_valid_reg && (!done_byte || out_free);
    assign rx_ready  = !s1_valid_reg || s1_go;
    assign rx_fire   = rx_valid && rx_ready;

    assign sum_x_next     = sum_x_reg + held_x_reg;
    assign sum_y_next     = sum_y_reg + held_y_reg;
    assign sum_wheel_next = sum_wheel_reg + held_wheel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (rx_fire)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_fire)
        begin
            s1_byte_reg <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg          <= '0;
            off_reg          <= '0;
            held_buttons_reg <= '0;
            held_x_reg       <= '0;
            held_y_reg       <= '0;
            held_wheel_reg   <= '0;
            sum_x_reg        <= '0;
            sum_y_reg        <= '0;
            sum_wheel_reg    <= '0;
        end
        else if (s1_go)
        begin
            if (hunting)
            begin
                if (s1_byte_reg == sync_byte(hdr_reg))
                begin
                    hdr_reg <= hdr_reg + 3'd1;
                    if (hdr_reg + 3'd1 == HDR_LEN)
                    begin
                        off_reg <= OFF_HDR_END;
                    end
                end
                else
                begin
                    hdr_reg <= (s1_byte_reg == SYNC_0) ? 3'd1 : 3'd0;
                end
            end
            else
            begin
                if (off_reg == OFF_BUTTONS)
                begin
                    held_buttons_reg <= s1_byte_reg;
                end
                if (off_reg == OFF_X)
                begin
                    held_x_reg <= s1_byte_reg;
                end
                if (off_reg == OFF_Y)
                begin
                    held_y_reg <= s1_byte_reg;
                end
                if (off_reg == OFF_WHEEL)
                begin
                    held_wheel_reg <= s1_byte_reg;
                end
                if (done_byte)
                begin
                    sum_x_reg     <= sum_x_next;
                    sum_y_reg     <= sum_y_next;
                    sum_wheel_reg <= sum_wheel_next;
                    hdr_reg       <= '0;
                    off_reg       <= '0;
                end
                else
                begin
                    off_reg <= off_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && done_byte)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (report_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // The completing byte never captures a field, so the held values are final.
    always_ff @(posedge clk)
    begin
        if (s1_go && done_byte)
        begin
            out_buttons_reg <= held_buttons_reg;
            out_x_reg       <= held_x_reg;
            out_y_reg       <= held_y_reg;
            out_wheel_reg   <= held_wheel_reg;
        end
    end

    assign report_valid = out_valid_reg;
    assign button_bits  = out_buttons_reg;
    assign x_delta      = out_x_reg;
    assign y_delta      = out_y_reg;
    assign wheel_delta  = out_wheel_reg;
    assign x_total      = sum_x_reg;
    assign y_total      = sum_y_reg;
    assign wheel_total  = sum_wheel_reg;

endmodule

### src/mrd_checker.sv
module mrd_checker
    import mrd_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              report_valid,
    input logic              report_ready,
    input logic [7:0]        button_bits,
    input logic signed [7:0] x_delta,
    input logic signed [7:0] y_delta,
    input logic signed [7:0] wheel_delta,
    input logic signed [7:0] x_total,
    input logic signed [7:0] y_total,
    input logic signed [7:0] wheel_total
);

    logic  report_fire;
    byte_t prev_x_reg;
    byte_t prev_y_reg;
    byte_t prev_wheel_reg;

    assign report_fire = report_valid && report_ready;

    // Totals of the last report taken; reset totals are zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            prev_wheel_reg <= '0;
        end
        else if (report_fire)
        begin
            prev_x_reg     <= x_total;
            prev_y_reg     <= y_total;
            prev_wheel_reg <= wheel_total;
        end
    end

    a_report_hold: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid && !report_ready |=> report_valid && $stable(button_bits)
            && $stable(x_delta) && $stable(y_delta) && $stable(wheel_delta)
            && $stable(x_total) && $stable(y_total) && $stable(wheel_total))
        else $error("report word changed while stalled");

    a_x_total: assert property (@(posedge clk) disable iff (!rst_n)
        report_fire |-> byte_t'(x_total) == byte_t'(prev_x_reg + byte_t'(x_delta)))
        else $error("x total does not follow previous total plus delta");

    a_y_total: assert property (@(posedge clk) disable iff (!rst_n)
        report_fire |-> byte_t'(y_total) == byte_t'(prev_y_reg + byte_t'(y_delta)))
        else $error("y total does not follow previous total plus delta");

    a_wheel_total: assert property (@(posedge clk) disable iff (!rst_n)
        report_fire |->
            byte_t'(wheel_total) == byte_t'(prev_wheel_reg + byte_t'(wheel_delta)))
        else $error("wheel total does not follow previous total plus delta");

endmodule

bind mouse_report_deframer mrd_checker u_mrd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .report_valid (report_valid),
    .report_ready (report_ready),
    .button_bits  (button_bits),
    .x_delta      (x_delta),
    .y_delta      (y_delta),
    .wheel_delta  (wheel_delta),
    .x_total      (x_total),
    .y_total      (y_total),
    .wheel_total  (wheel_total)
);

### verif/mouse_report_deframer_test.sv
`timescale 1ns / 1ps

module mouse_report_deframer_test
    import mrd_pkg::*;
();

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_WORDS = 1450;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_FRAMES  = 4;

    typedef struct {
        byte_t             buttons;
        logic signed [7:0] dx;
        logic signed [7:0] dy;
        logic signed [7:0] dw;
        logic signed [7:0] tx;
        logic signed [7:0] ty;
        logic signed [7:0] tw;
    } mouse_report_t;

    logic              clk;
    logic              rst_n;
    logic              rx_valid;
    logic              rx_ready;
    logic [7:0]        rx_byte;
    logic              report_valid;
    logic              report_ready;
    logic [7:0]        button_bits;
    logic signed [7:0] x_delta;
    logic signed [7:0] y_delta;
    logic signed [7:0] wheel_delta;
    logic signed [7:0] x_total;
    logic signed [7:0] y_total;
    logic signed [7:0] wheel_total;

    // Mirror of the block's state, updated as each word is accepted.
    byte_t      sync_seq [5] = '{SYNC_0, SYNC_1, SYNC_2, SYNC_3, SYNC_4};
    hdr_count_t hunt_count   = '0;
    frame_off_t frame_pos    = '0;
    byte_t      cap_buttons  = '0;
    byte_t      cap_x        = '0;
    byte_t      cap_y        = '0;
    byte_t      cap_wheel    = '0;
    byte_t      run_x        = '0;
    byte_t      run_y        = '0;
    byte_t      run_wheel    = '0;

    mouse_report_t pending_reports [$];
    int            mismatch_count = 0;
    int            words_sent     = 0;
    int            burst_left     = 0;
    int            stall_pct      = 0;
    int            phase_left     = 0;
    bit            hold_request   = 1'b0;
    bit            holding        = 1'b0;

    mouse_report_deframer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_valid     (rx_valid),
        .rx_ready     (rx_ready),
        .rx_byte      (rx_byte),
        .report_valid (report_valid),
        .report_ready (report_ready),
        .button_bits  (button_bits),
        .x_delta      (x_delta),
        .y_delta      (y_delta),
        .wheel_delta  (wheel_delta),
        .x_total      (x_total),
        .y_total      (y_total),
        .wheel_total  (wheel_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic void deframe_byte(input byte_t b);
        mouse_report_t r;
        if (hunt_count < HDR_LEN)
        begin
            if (b == sync_seq[hunt_count])
            begin
                hunt_count = hunt_count + 3'd1;
                if (hunt_count == HDR_LEN)
                    frame_pos = OFF_HDR_END;
            end
            else
                hunt_count = (b == SYNC_0) ? 3'd1 : 3'd0;
            return;
        end
        case (frame_pos)
            OFF_BUTTONS: cap_buttons = b;
            OFF_X:       cap_x = b;
            OFF_Y:       cap_y = b;
            OFF_WHEEL:   cap_wheel = b;
            default:     ;
        endcase
        if (frame_pos < OFF_LAST)
        begin
            frame_pos = frame_pos + 4'd1;
            return;
        end
        run_x     = run_x + cap_x;
        run_y     = run_y + cap_y;
        run_wheel = run_wheel + cap_wheel;
        r.buttons = cap_buttons;
        r.dx      = cap_x;
        r.dy      = cap_y;
        r.dw      = cap_wheel;
        r.tx      = run_x;
        r.ty      = run_y;
        r.tw      = run_wheel;
        pending_reports.push_back(r);
        hunt_count = '0;
        frame_pos  = '0;
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got, input bit is_signed);
        if (got !== want)
        begin
            if (is_signed)
                $error("%s expected %0d actual %0d", name, $signed(want), $signed(got));
            else
                $error("%s expected 0x%02h actual 0x%02h", name, want, got);
            mismatch_count++;
        end
    endfunction

    task automatic check_report();
        mouse_report_t want;
        if (pending_reports.size() == 0)
        begin
            $error("report with no frame pending: button_bits 0x%02h x_delta %0d",
                   button_bits, x_delta);
            mismatch_count++;
            return;
        end
        want = pending_reports.pop_front();
        compare_field("button_bits", want.buttons, button_bits, 1'b0);
        compare_field("x_delta", want.dx, x_delta, 1'b1);
        compare_field("y_delta", want.dy, y_delta, 1'b1);
        compare_field("wheel_delta", want.dw, wheel_delta, 1'b1);
        compare_field("x_total", want.tx, x_total, 1'b1);
        compare_field("y_total", want.ty, y_total, 1'b1);
        compare_field("wheel_total", want.tw, wheel_total, 1'b1);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && report_valid && report_ready)
            check_report();
    end

    // Receiver: stall rate changes at the end of each randomly sized phase, with an occasional
    // long hold-off requested by the pressure test.
    initial
    begin
        report_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                holding = 1'b1;
                report_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
                holding = 1'b0;
            end
            else
            begin
                if (phase_left == 0)
                begin
                    phase_left = $urandom_range(20, 200);
                    case ($urandom_range(0, 3))
                        0:       stall_pct = 0;
                        1:       stall_pct = 30;
                        2:       stall_pct = 60;
                        default: stall_pct = 90;
                    endcase
                end
                phase_left--;
                report_ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Sends one word; between bursts valid drops for a random gap.
    task automatic send_byte(input byte_t b);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            gap = $urandom_range(1, 5);
            rx_valid <= 1'b0;
            rx_byte  <= byte_t'($urandom);
            repeat (gap) @(posedge clk);
        end
        burst_left--;
        rx_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!rx_ready)
            @(posedge clk);
        deframe_byte(b);
        words_sent++;
    endtask

    function automatic byte_t pick_byte();
        byte_t v;
        case ($urandom_range(0, 9))
            0:       v = 8'h00;
            1:       v = 8'h7F;
            2:       v = 8'h80;
            3:       v = 8'hFF;
            default: v = byte_t'($urandom);
        endcase
        return v;
    endfunction

    // Full frame; with sync_filler set, the filler at unused offsets may mimic header bytes.
    task automatic send_frame(input bit sync_filler);
        byte_t fill;
        for (int i = 0; i < 5; i++)
            send_byte(sync_seq[i]);
        for (frame_off_t off = OFF_HDR_END; off <= OFF_LAST; off++)
        begin
            fill = sync_filler ? sync_seq[$urandom_range(0, 4)] : byte_t'($urandom);
            if (off == OFF_BUTTONS || off == OFF_X || off == OFF_Y || off == OFF_WHEEL)
                send_byte(pick_byte());
            else
                send_byte(fill);
            if (off == OFF_LAST)
                break;
        end
    endtask

    task automatic send_broken_header();
        int    depth;
        byte_t b;
        depth = $urandom_range(1, 4);
        for (int i = 0; i < depth; i++)
            send_byte(sync_seq[i]);
        b = ($urandom_range(0, 2) == 0) ? SYNC_0 : byte_t'($urandom);
        send_byte(b);
    endtask

    // Restart on a repeated first header byte, header values in the ignored
    // slots, extreme field values, then mismatches at several depths.
    task automatic test_sync_hunt();
        byte_t hunt_seq [25];
        hunt_seq = '{SYNC_0, SYNC_0, SYNC_1, SYNC_2, SYNC_3, SYNC_4,
                     SYNC_0, SYNC_1, 8'hFF, 8'h7F, SYNC_2, 8'h80, SYNC_3, 8'h80, SYNC_4,
                     8'hAB, 8'h00, SYNC_0, SYNC_1, SYNC_2, SYNC_3, SYNC_0, SYNC_1,
                     SYNC_4, 8'hFF};
        foreach (hunt_seq[i])
            send_byte(hunt_seq[i]);
    endtask

    // Keep feeding frames while the receiver holds off, so the block fills
    // and has to stall its input.
    task automatic test_report_backpressure();
        hold_request = 1'b1;
        while (!holding)
            @(posedge clk);
        for (int i = 0; i < HOLD_FRAMES; i++)
            send_frame(1'b0);
    endtask

    task automatic test_random_stream();
        int target;
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2:
                begin
                    repeat ($urandom_range(1, 8))
                        send_byte(byte_t'($urandom));
                end
                3, 4:    send_broken_header();
                5:       send_frame(1'b1);
                default: send_frame(1'b0);
            endcase
        end
    endtask

    initial
    begin
        rst_n    <= 1'b0;
        rx_valid <= 1'b0;
        rx_byte  <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_sync_hunt();
        test_report_backpressure();
        test_random_stream();

        rx_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

### sim.f
src/mrd_pkg.sv
src/mouse_report_deframer.sv
src/mrd_checker.sv
verif/mouse_report_deframer_test.sv
